// ===== sv/mcg_pkg.sv =====
package mcg_pkg;

   // field widths
   localparam int YearW  = 14;
   localparam int MonthW = 4;
   localparam int CellW  = 6;
   localparam int DayW   = 5;
   localparam int FirstW = 3;

   // calendar constants
   localparam logic [YearW-1:0]  ReformYear  = 14'd1752;
   localparam logic [YearW-1:0]  JulianCut   = 14'd1700;
   localparam logic [YearW-1:0]  QuadCut     = 14'd1600;
   localparam logic [MonthW-1:0] MonthSept   = 4'd8;
   localparam logic [MonthW-1:0] MonthMar    = 4'd2;
   localparam logic [MonthW-1:0] MonthDec    = 4'd11;
   localparam logic [FirstW-1:0] ReformFirst = 3'd2;
   localparam logic [DayW-1:0]   ReformSpan  = 5'd19;
   localparam logic [CellW-1:0]  CellLast    = 6'd41;

   // reciprocals for division by constants
   localparam int          ProdW     = 27;
   localparam int          Rcp100Sh  = 19;
   localparam logic [12:0] Rcp100    = 13'd5243;
   localparam int          Prod7W    = 30;
   localparam int          Rcp7Sh    = 17;
   localparam logic [14:0] Rcp7      = 15'd18725;

   // weekday bias before and after the reform, including the day-one offset
   localparam logic [14:0] BiasOld   = 15'd6;
   localparam logic [14:0] BiasNew   = 15'd2;

   // one date resolved to grid placement
   typedef struct packed {
      logic [FirstW-1:0] ofs;
      logic [CellW-1:0]  last;
      logic              bad;
      logic              reform;
   } mcg_date_type;

   // days in month, zero-based month
   function automatic logic [DayW-1:0] month_len(input logic leap,
                                                 input logic [MonthW-1:0] m);
      logic [DayW-1:0] len;
      case (m)
         4'd1:    len = leap ? 5'd29 : 5'd28;
         4'd3:    len = 5'd30;
         4'd5:    len = 5'd30;
         4'd8:    len = 5'd30;
         4'd10:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

   // days before the month in a common year
   function automatic logic [8:0] month_start(input logic [MonthW-1:0] m);
      logic [8:0] d;
      case (m)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd59;
         4'd3:    d = 9'd90;
         4'd4:    d = 9'd120;
         4'd5:    d = 9'd151;
         4'd6:    d = 9'd181;
         4'd7:    d = 9'd212;
         4'd8:    d = 9'd243;
         4'd9:    d = 9'd273;
         4'd10:   d = 9'd304;
         4'd11:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

// ===== sv/mcg_date_pipe.sv =====
module mcg_date_pipe (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [mcg_pkg::YearW-1:0]     req_year,
   input  logic [mcg_pkg::MonthW-1:0]    req_month,
   input  logic                          som,
   output logic                          date_valid,
   output mcg_pkg::mcg_date_type         date,
   input  logic                          date_ready
);
   import mcg_pkg::*;

   // stage a: input capture
   logic              a_v_ff;
   logic [YearW-1:0]  a_y_ff, a_ym1_ff;
   logic [MonthW-1:0] a_m_ff;
   logic              a_bad_ff, a_reform_ff, a_before_ff, a_som_ff;
   // stage b: quotients
   logic              b_v_ff;
   logic [YearW-1:0]  b_y_ff, b_ym1_ff;
   logic [MonthW-1:0] b_m_ff;
   logic              b_bad_ff, b_reform_ff, b_before_ff, b_som_ff;
   logic [7:0]        b_q100_ff, b_q400_ff, b_yq100_ff, b_yq400_ff;
   // stage c: leap count, leap flag, month offset
   logic              c_v_ff;
   logic [YearW-1:0]  c_ym1_ff;
   logic [MonthW-1:0] c_m_ff;
   logic              c_bad_ff, c_reform_ff, c_before_ff, c_som_ff, c_leap_ff;
   logic [12:0]       c_lp_ff;
   logic [8:0]        c_cum_ff;
   // stage d: weekday sum
   logic              d_v_ff;
   logic [14:0]       d_s_ff;
   logic [DayW-1:0]   d_span_ff;
   logic              d_bad_ff, d_reform_ff, d_som_ff;
   // stage e: quotient by seven
   logic              e_v_ff;
   logic [14:0]       e_s_ff;
   logic [12:0]       e_q7_ff;
   logic [DayW-1:0]   e_span_ff;
   logic              e_bad_ff, e_reform_ff, e_som_ff;
   // stage f: placement
   logic              f_v_ff;
   mcg_date_type      f_date_ff;

   logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_f;

   logic [ProdW-1:0]  p_q100, p_q400, p_yq100, p_yq400;
   logic [11:0]       t400;
   logic [12:0]       lp_in;
   logic              y4, not100, by400, leap_in;
   logic [14:0]       s_in;
   logic [Prod7W-1:0] p_q7;
   logic [14:0]       rem15;
   logic [FirstW-1:0] wd, st, ofs_in;
   logic [DayW-1:0]   span_eff;
   mcg_date_type      date_in;

   // stall chain
   assign rdy_f = !f_v_ff || date_ready;
   assign rdy_e = !e_v_ff || rdy_f;
   assign rdy_d = !d_v_ff || rdy_e;
   assign rdy_c = !c_v_ff || rdy_d;
   assign rdy_b = !b_v_ff || rdy_c;
   assign rdy_a = !a_v_ff || rdy_b;
   assign busy  = !rdy_a;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
         e_v_ff <= 1'b0;
         f_v_ff <= 1'b0;
      end else begin
         if (rdy_a) a_v_ff <= start;
         if (rdy_b) b_v_ff <= a_v_ff;
         if (rdy_c) c_v_ff <= b_v_ff;
         if (rdy_d) d_v_ff <= c_v_ff;
         if (rdy_e) e_v_ff <= d_v_ff;
         if (rdy_f) f_v_ff <= e_v_ff;
      end
   end

   // stage a
   always_ff @(posedge clock) begin
      if (rdy_a) begin
         a_y_ff      <= req_year;
         a_ym1_ff    <= req_year - 14'd1;
         a_m_ff      <= req_month;
         a_bad_ff    <= (req_month > MonthDec) || (req_year == '0);
         a_reform_ff <= (req_year == ReformYear) && (req_month == MonthSept);
         a_before_ff <= (req_year < ReformYear) ||
                        ((req_year == ReformYear) && (req_month < MonthSept));
         a_som_ff    <= som;
      end
   end

   // divisions by 100 and 400 through reciprocal products
   assign t400    = (a_ym1_ff > QuadCut) ? 12'((a_ym1_ff - QuadCut) >> 2) : 12'd0;
   assign p_q100  = ProdW'(a_ym1_ff) * ProdW'(Rcp100);
   assign p_q400  = ProdW'(t400) * ProdW'(Rcp100);
   assign p_yq100 = ProdW'(a_y_ff) * ProdW'(Rcp100);
   assign p_yq400 = ProdW'(a_y_ff[YearW-1:2]) * ProdW'(Rcp100);

   // stage b
   always_ff @(posedge clock) begin
      if (rdy_b) begin
         b_y_ff      <= a_y_ff;
         b_ym1_ff    <= a_ym1_ff;
         b_m_ff      <= a_m_ff;
         b_bad_ff    <= a_bad_ff;
         b_reform_ff <= a_reform_ff;
         b_before_ff <= a_before_ff;
         b_som_ff    <= a_som_ff;
         b_q100_ff   <= p_q100[ProdW-1:Rcp100Sh];
         b_q400_ff   <= p_q400[ProdW-1:Rcp100Sh];
         b_yq100_ff  <= p_yq100[ProdW-1:Rcp100Sh];
         b_yq400_ff  <= p_yq400[ProdW-1:Rcp100Sh];
      end
   end

   // leap years through the previous year, and this year's leap flag
   always_comb begin
      lp_in = 13'(b_ym1_ff[YearW-1:2]);
      if (b_ym1_ff > JulianCut) lp_in = lp_in - (13'(b_q100_ff) - 13'd17);
      if (b_ym1_ff > QuadCut)   lp_in = lp_in + 13'(b_q400_ff);
      y4      = (b_y_ff[1:0] == 2'b00);
      not100  = (b_y_ff != 14'(14'(b_yq100_ff) * 14'd100));
      by400   = y4 && (b_y_ff[YearW-1:2] == 12'(12'(b_yq400_ff) * 12'd100));
      leap_in = (b_y_ff <= ReformYear) ? y4 : ((y4 && not100) || by400);
   end

   // stage c
   always_ff @(posedge clock) begin
      if (rdy_c) begin
         c_ym1_ff    <= b_ym1_ff;
         c_m_ff      <= b_m_ff;
         c_bad_ff    <= b_bad_ff;
         c_reform_ff <= b_reform_ff;
         c_before_ff <= b_before_ff;
         c_som_ff    <= b_som_ff;
         c_leap_ff   <= leap_in;
         c_lp_ff     <= lp_in;
         c_cum_ff    <= month_start(b_m_ff);
      end
   end

   // day count folded mod 7, since 365 is one mod 7
   assign s_in = 15'(c_ym1_ff) + 15'(c_lp_ff) + 15'(c_cum_ff)
               + 15'(c_leap_ff && (c_m_ff >= MonthMar))
               + (c_before_ff ? BiasOld : BiasNew);

   // stage d
   always_ff @(posedge clock) begin
      if (rdy_d) begin
         d_s_ff      <= s_in;
         d_span_ff   <= month_len(c_leap_ff, c_m_ff);
         d_bad_ff    <= c_bad_ff;
         d_reform_ff <= c_reform_ff;
         d_som_ff    <= c_som_ff;
      end
   end

   assign p_q7 = Prod7W'(d_s_ff) * Prod7W'(Rcp7);

   // stage e
   always_ff @(posedge clock) begin
      if (rdy_e) begin
         e_s_ff      <= d_s_ff;
         e_q7_ff     <= p_q7[Prod7W-1:Rcp7Sh];
         e_span_ff   <= d_span_ff;
         e_bad_ff    <= d_bad_ff;
         e_reform_ff <= d_reform_ff;
         e_som_ff    <= d_som_ff;
      end
   end

   // weekday, column shift and last filled cell
   always_comb begin
      rem15    = e_s_ff - 15'(15'(e_q7_ff) * 15'd7);
      wd       = rem15[FirstW-1:0];
      st       = e_reform_ff ? ReformFirst : wd;
      if (e_som_ff) ofs_in = (st == '0) ? 3'd6 : st - 3'd1;
      else          ofs_in = st;
      span_eff = e_reform_ff ? ReformSpan : e_span_ff;
      date_in.reform = e_reform_ff;
      date_in.bad    = e_bad_ff;
      if (e_bad_ff) begin
         date_in.ofs  = '0;
         date_in.last = '0;
      end else begin
         date_in.ofs  = ofs_in;
         date_in.last = 6'(ofs_in) + 6'(span_eff) - 6'd1;
      end
   end

   // stage f
   always_ff @(posedge clock) begin
      if (rdy_f) f_date_ff <= date_in;
   end

   assign date_valid = f_v_ff;
   assign date       = f_date_ff;

endmodule

// ===== sv/mcg_cell_emit.sv =====
module mcg_cell_emit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          date_valid,
   input  mcg_pkg::mcg_date_type         date,
   output logic                          date_ready,
   output logic                          rsp_valid,
   output logic [mcg_pkg::CellW-1:0]     rsp_cell_index,
   output logic [mcg_pkg::DayW-1:0]      rsp_day_number,
   output logic [mcg_pkg::FirstW-1:0]    rsp_first_cell,
   output logic [mcg_pkg::CellW-1:0]     rsp_last_cell,
   output logic                          rsp_bad_date,
   output logic                          rsp_final_item
);
   import mcg_pkg::*;

   logic             active_ff;
   logic [CellW-1:0] cnt_ff;
   mcg_date_type     cur_ff;

   logic             rsp_valid_ff, rsp_bad_ff, rsp_final_ff;
   logic [CellW-1:0] rsp_cell_ff, rsp_last_ff;
   logic [DayW-1:0]  rsp_day_ff;
   logic [FirstW-1:0] rsp_first_ff;

   logic             load;
   logic             in_range;
   logic [CellW-1:0] k;
   logic [DayW-1:0]  day_in;

   // next item loads as the last cell goes out
   assign load       = !active_ff || (cnt_ff == CellLast);
   assign date_ready = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (load) begin
         active_ff <= date_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cnt_ff <= '0;
         cur_ff <= date;
      end else begin
         cnt_ff <= cnt_ff + 6'd1;
      end
   end

   // day number of the current cell; the reform month skips from 2 to 14
   always_comb begin
      in_range = !cur_ff.bad && (cnt_ff >= 6'(cur_ff.ofs)) && (cnt_ff <= cur_ff.last);
      k        = cnt_ff - 6'(cur_ff.ofs);
      if (!in_range)                     day_in = '0;
      else if (cur_ff.reform && k >= 6'd2) day_in = 5'(k + 6'd12);
      else                               day_in = 5'(k + 6'd1);
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= active_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_cell_ff  <= cnt_ff;
      rsp_day_ff   <= day_in;
      rsp_first_ff <= cur_ff.ofs;
      rsp_last_ff  <= cur_ff.last;
      rsp_bad_ff   <= cur_ff.bad;
      rsp_final_ff <= (cnt_ff == CellLast);
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_index = rsp_cell_ff;
   assign rsp_day_number = rsp_day_ff;
   assign rsp_first_cell = rsp_first_ff;
   assign rsp_last_cell  = rsp_last_ff;
   assign rsp_bad_date   = rsp_bad_ff;
   assign rsp_final_item = rsp_final_ff;

endmodule

// ===== sv/month_calendar_grid_core.sv =====
// path: an item taken at start passes the input capture stage, five more date stages,
//   the cell counter and the result register before cell 0 is on the rsp ports
// throughput: one cell per cycle from the cell counter, through cell 41 of each item
// start is taken whenever busy is low, also while an earlier item is still in the date stages or being emitted
// results are never stalled by the receiver
// reset: synchronous, clears all valid bits and the monday-first setting
module month_calendar_grid_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [mcg_pkg::YearW-1:0]     req_year,
   input  logic [mcg_pkg::MonthW-1:0]    req_month,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_monday_first,
   output logic                          rsp_valid,
   output logic [mcg_pkg::CellW-1:0]     rsp_cell_index,
   output logic [mcg_pkg::DayW-1:0]      rsp_day_number,
   output logic [mcg_pkg::FirstW-1:0]    rsp_first_cell,
   output logic [mcg_pkg::CellW-1:0]     rsp_last_cell,
   output logic                          rsp_bad_date,
   output logic                          rsp_final_item
);
   import mcg_pkg::*;

   logic         som_ff;
   logic         date_valid, date_ready;
   mcg_date_type date;

   // configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         som_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         som_ff <= csr_monday_first;
      end
   end

   mcg_date_pipe u_pipe (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_year   (req_year),
      .req_month  (req_month),
      .som        (som_ff),
      .date_valid (date_valid),
      .date       (date),
      .date_ready (date_ready)
   );

   mcg_cell_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .date_valid     (date_valid),
      .date           (date),
      .date_ready     (date_ready),
      .rsp_valid      (rsp_valid),
      .rsp_cell_index (rsp_cell_index),
      .rsp_day_number (rsp_day_number),
      .rsp_first_cell (rsp_first_cell),
      .rsp_last_cell  (rsp_last_cell),
      .rsp_bad_date   (rsp_bad_date),
      .rsp_final_item (rsp_final_item)
   );

endmodule

// ===== sv/mcg_checker.sv =====
module mcg_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic [mcg_pkg::CellW-1:0]     rsp_cell_index,
   input logic [mcg_pkg::DayW-1:0]      rsp_day_number,
   input logic [mcg_pkg::FirstW-1:0]    rsp_first_cell,
   input logic [mcg_pkg::CellW-1:0]     rsp_last_cell,
   input logic                          rsp_bad_date,
   input logic                          rsp_final_item
);
   import mcg_pkg::*;

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe after reset");

   // final item marks the last cell only
   a_final_cell: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_final_item == (rsp_cell_index == CellLast)))
      else $error("final_item does not match cell 41");

   // cells of one item come on consecutive cycles in order
   a_cell_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_final_item |=>
         rsp_valid && (rsp_cell_index == $past(rsp_cell_index) + 6'd1))
      else $error("cell sequence broken");

   // placement holds across one item
   a_place_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_final_item |=>
         $stable(rsp_first_cell) && $stable(rsp_last_cell) && $stable(rsp_bad_date))
      else $error("placement changed within an item");

   // a bad date yields a blank grid
   a_bad_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_date |->
         (rsp_day_number == '0) && (rsp_first_cell == '0) && (rsp_last_cell == '0))
      else $error("bad date with filled cell");

endmodule

bind month_calendar_grid_core mcg_checker u_chk (.*);
